[src/rcf_pkg.sv]
// Shared constants, types and kernel coefficient table for the RGB 3x3 convolution filter.
package rcf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  // Rows get two spare bits: the input row runs past the frame height while the tail drains.
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 2;
  localparam int SEL_W      = 3;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int TAP_W      = 5;
  localparam int SUM_W      = 14;
  localparam int NUM_TAPS   = 9;
  localparam int TAP_IDX_W  = $clog2(NUM_TAPS);
  localparam int NUM_KERNELS = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Kernel codes.
  localparam logic [SEL_W-1:0] K_BOX     = 3'd0;
  localparam logic [SEL_W-1:0] K_GAUSS   = 3'd1;
  localparam logic [SEL_W-1:0] K_OUTLINE = 3'd2;
  localparam logic [SEL_W-1:0] K_EMBOSS  = 3'd3;
  localparam logic [SEL_W-1:0] K_SHARPEN = 3'd4;

  localparam logic [SEL_W-1:0]   RST_KERNEL = K_BOX;
  localparam logic [IMG_W_W-1:0] RST_WIDTH  = 12'd640;
  localparam logic [IMG_H_W-1:0] RST_HEIGHT = 13'd480;

  // Reciprocal of 9 in 16 fractional bits; exact floor for sums up to the box blur maximum.
  localparam int RECIP9_SHIFT = 16;
  localparam int RECIP9       = ((1 << RECIP9_SHIFT) + 8) / 9;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             emit;
    logic             interior;
    logic             last;
    logic [SEL_W-1:0] sel;
  } item_info_t;

  // Taps in raster order: row 0 meets the row above, column 0 the column to the left.
  localparam logic signed [TAP_W-1:0] KTAPS [NUM_KERNELS][NUM_TAPS] = '{
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{-5'sd2, -5'sd1,  5'sd0, -5'sd1,  5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd2},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd5, -5'sd1,  5'sd0, -5'sd1,  5'sd0}
  };

  function automatic logic signed [TAP_W-1:0] tap_coef(input logic [SEL_W-1:0] sel,
                                                       input logic [TAP_IDX_W-1:0] k);
    logic signed [TAP_W-1:0] c;
    c = '0;
    if (sel <= K_SHARPEN && 32'(k) < NUM_TAPS) begin
      c = KTAPS[sel][k];
    end
    return c;
  endfunction

endpackage

[src/rgb_3x3_convolution_filter.sv]
// Top level of the RGB 3x3 convolution filter: line store, window, filter and output register.
// Path: a pixel that yields a result goes through line store read, window shift, tap sums, then
// divide and clamp into the output register; the result of raster pixel n comes with input item
// n + W + 1, so W + 1 flush items drain a frame. Throughput: one item per clock unless out_stall
// backs up the pipeline; the single line store is read and written at most once per cycle.
// Reset (synchronous, rst_n low) clears the counters, the window and all stage valids and loads
// kernel 0 and a 640 x 480 frame; the line store is not cleared.
module rgb_3x3_convolution_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic [rcf_pkg::CH_W-1:0]             in_red_in,
  input  logic [rcf_pkg::CH_W-1:0]             in_green_in,
  input  logic [rcf_pkg::CH_W-1:0]             in_blue_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rcf_pkg::CH_W-1:0]             out_red_out,
  output logic [rcf_pkg::CH_W-1:0]             out_green_out,
  output logic [rcf_pkg::CH_W-1:0]             out_blue_out,
  output logic                                 out_frame_last
);

  localparam int COL_W = rcf_pkg::COL_W;
  localparam int ROW_W = rcf_pkg::ROW_W;
  localparam int CH_W  = rcf_pkg::CH_W;
  localparam int PIX_W = rcf_pkg::PIX_W;
  localparam int SUM_W = rcf_pkg::SUM_W;
  localparam int NTAP  = rcf_pkg::NUM_TAPS;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. The user writes only while the block is idle; the block does not check it.
  // ---------------------------------------------------------------------------------------
  logic [rcf_pkg::SEL_W-1:0]   kernel_sel_r;
  logic [rcf_pkg::IMG_W_W-1:0] img_w_r;
  logic [rcf_pkg::IMG_H_W-1:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_sel_r <= rcf_pkg::RST_KERNEL;
      img_w_r      <= rcf_pkg::RST_WIDTH;
      img_h_r      <= rcf_pkg::RST_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rcf_pkg::CFG_KERNEL: kernel_sel_r <= cfg_wdata[rcf_pkg::SEL_W-1:0];
        rcf_pkg::CFG_WIDTH:  img_w_r      <= cfg_wdata[rcf_pkg::IMG_W_W-1:0];
        rcf_pkg::CFG_HEIGHT: img_h_r      <= cfg_wdata[rcf_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero becomes one, oversize values are held to MAX_WIDTH and MAX_HEIGHT.
  logic [COL_W:0]   dim_w;
  logic [ROW_W-1:0] dim_h;

  always_comb begin
    if (img_w_r == '0) begin
      dim_w = (COL_W+1)'(1);
    end else if (32'(img_w_r) > 32'(rcf_pkg::MAX_WIDTH)) begin
      dim_w = (COL_W+1)'(rcf_pkg::MAX_WIDTH);
    end else begin
      dim_w = (COL_W+1)'(img_w_r);
    end
    if (img_h_r == '0) begin
      dim_h = ROW_W'(1);
    end else if (32'(img_h_r) > 32'(rcf_pkg::MAX_HEIGHT)) begin
      dim_h = ROW_W'(rcf_pkg::MAX_HEIGHT);
    end else begin
      dim_h = ROW_W'(img_h_r);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage valids and the ready chain. Each stage moves on when the one after it is empty or
  // moving, so bubbles collapse and the input flows on while a result waits, until the stages fill.
  // ---------------------------------------------------------------------------------------
  logic s1_v_r, w_v_r, s_v_r, o_v_r;
  logic rdy_o, rdy_s, rdy_w, rdy_1;
  logic accept, take, s1_go;

  assign rdy_o    = !o_v_r || !out_stall;
  assign rdy_s    = !s_v_r || rdy_o;
  assign rdy_w    = !w_v_r || rdy_s;
  assign rdy_1    = !s1_v_r || rdy_w;
  assign in_stall = !rdy_1;
  assign accept   = in_valid && rdy_1;
  assign s1_go    = s1_v_r && rdy_w;

  // ---------------------------------------------------------------------------------------
  // Frame position counters, advanced in item order at acceptance.
  // ---------------------------------------------------------------------------------------
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic             done, emit, interior, last, col_wrap;
  logic [COL_W:0]   col_inc, ox_inc;
  logic [ROW_W-1:0] oy_inc;
  rcf_pkg::pix_t    in_pix;
  rcf_pkg::item_info_t in_info;

  always_comb begin
    done = in_row_r >= dim_h;
    // A flush before the frame is complete is swallowed without touching any state.
    take = accept && !(in_func && !done);
    in_pix = done ? '0 : {in_red_in, in_green_in, in_blue_in};

    col_inc  = {1'b0, in_col_r} + 1'b1;
    col_wrap = col_inc >= dim_w;
    emit     = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);

    ox_inc   = {1'b0, out_col_r} + 1'b1;
    oy_inc   = out_row_r + 1'b1;
    interior = kernel_sel_r <= rcf_pkg::K_SHARPEN && out_col_r != '0 && ox_inc < dim_w &&
               out_row_r != '0 && oy_inc < dim_h;
    last     = oy_inc >= dim_h && ox_inc >= dim_w;

    in_info.emit     = emit;
    in_info.interior = interior;
    in_info.last     = last;
    in_info.sel      = kernel_sel_r;

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
      if (emit) begin
        if (last) begin
          // The frame's final pixel restarts every position counter.
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ox_inc >= dim_w) begin
          out_col_nxt = '0;
          out_row_nxt = oy_inc;
        end else begin
          out_col_nxt = ox_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Line store: each entry holds the pixel two rows up (upper half) and one row up (lower
  // half) for its column. Read at acceptance, written back when the item leaves stage one.
  // ---------------------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [rcf_pkg::MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q_r, byp_r, eff_rd, wr_data;
  logic               byp_sel_r, byp_hit;
  rcf_pkg::pix_t      s1_pix_r, eff_top, eff_mid;
  logic [COL_W-1:0]   s1_col_r;
  rcf_pkg::item_info_t s1_info_r;

  // The store reads before it writes; when the item just ahead writes the very column that
  // is read in the same cycle (a one-pixel-wide frame), its write data is forwarded instead.
  assign eff_rd  = byp_sel_r ? byp_r : rd_q_r;
  assign eff_top = eff_rd[2*PIX_W-1:PIX_W];
  assign eff_mid = eff_rd[PIX_W-1:0];
  assign wr_data = {eff_mid, s1_pix_r};
  assign byp_hit = s1_go && (s1_col_r == in_col_r);

  always_ff @(posedge clk) begin
    if (take) begin
      rd_q_r <= line_mem[in_col_r];
    end
    if (s1_go) begin
      line_mem[s1_col_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy_1) begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r  <= in_pix;
      s1_col_r  <= in_col_r;
      s1_info_r <= in_info;
      byp_sel_r <= byp_hit;
      byp_r     <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------------------
  // 3x3 window: each row shifts left and takes the new column at its right end.
  // ---------------------------------------------------------------------------------------
  rcf_pkg::pix_t       win_r [NTAP];
  rcf_pkg::item_info_t w_info_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NTAP; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]   <= win_r[i*3+1];
        win_r[i*3+1] <= win_r[i*3+2];
      end
      win_r[2] <= eff_top;
      win_r[5] <= eff_mid;
      win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
    end else if (s1_go) begin
      w_v_r <= s1_info_r.emit;
    end else if (rdy_s) begin
      w_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      w_info_r <= s1_info_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tap sums: nine small constant products per channel, summed into a signed register.
  // ---------------------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_c [3];
  logic signed [SUM_W-1:0] s_sum_r [3];
  rcf_pkg::pix_t           s_ctr_r;
  logic                    s_interior_r, s_last_r;
  logic [rcf_pkg::SEL_W-1:0] s_sel_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int k = 0; k < NTAP; k++) begin
        sum_c[ch] = sum_c[ch] +
          SUM_W'(rcf_pkg::tap_coef(w_info_r.sel, rcf_pkg::TAP_IDX_W'(k))) *
          $signed({(SUM_W-CH_W)'(0), win_r[k][PIX_W-CH_W*(ch+1) +: CH_W]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (rdy_s) begin
      s_v_r <= w_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s && w_v_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        s_sum_r[ch] <= sum_c[ch];
      end
      s_ctr_r      <= win_r[4];
      s_interior_r <= w_info_r.interior;
      s_last_r     <= w_info_r.last;
      s_sel_r      <= w_info_r.sel;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Normalize and clamp: box blur divides by nine with rounding, Gaussian by sixteen, the
  // others use the sum as is. Border pixels and unknown kernels pass the center through.
  // ---------------------------------------------------------------------------------------
  localparam int RECIP9_W_PLUS = rcf_pkg::RECIP9_SHIFT;

  logic [CH_W-1:0] res_c [3];
  logic signed [SUM_W-1:0] norm;
  logic [SUM_W-1:0]        box_num;
  logic [SUM_W+RECIP9_W_PLUS-1:0] box_prod;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      box_num  = SUM_W'(s_sum_r[ch] + SUM_W'(4));
      box_prod = (SUM_W+RECIP9_W_PLUS)'(box_num) * (SUM_W+RECIP9_W_PLUS)'(rcf_pkg::RECIP9);
      case (s_sel_r)
        rcf_pkg::K_BOX: begin
          norm = $signed(SUM_W'(box_prod >> rcf_pkg::RECIP9_SHIFT));
        end
        rcf_pkg::K_GAUSS: begin
          norm = (s_sum_r[ch] + SUM_W'(8)) >>> 4;
        end
        default: begin
          norm = s_sum_r[ch];
        end
      endcase
      if (!s_interior_r) begin
        res_c[ch] = s_ctr_r[PIX_W-CH_W*(ch+1) +: CH_W];
      end else if (norm < 0) begin
        res_c[ch] = '0;
      end else if (norm > SUM_W'(255)) begin
        res_c[ch] = '1;
      end else begin
        res_c[ch] = norm[CH_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------------------
  logic [CH_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic            out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (rdy_o) begin
      o_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && s_v_r) begin
      out_red_r   <= res_c[0];
      out_green_r <= res_c[1];
      out_blue_r  <= res_c[2];
      out_last_r  <= s_last_r;
    end
  end

  assign out_valid      = o_v_r;
  assign out_red_out    = out_red_r;
  assign out_green_out  = out_green_r;
  assign out_blue_out   = out_blue_r;
  assign out_frame_last = out_last_r;

endmodule

[src/rcf_checker.sv]
// Port-level checker for the RGB 3x3 convolution filter and its bind statement.
module rcf_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [rcf_pkg::CH_W-1:0] out_red_out,
  input logic [rcf_pkg::CH_W-1:0] out_green_out,
  input logic [rcf_pkg::CH_W-1:0] out_blue_out,
  input logic                     out_frame_last
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out) && $stable(out_frame_last))
    else $error("stalled result changed");

  // The input only backs up when a result is waiting on a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with the output free");

  // Reset empties the pipeline, so nothing is shown right after it.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind rgb_3x3_convolution_filter rcf_checker u_rcf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out),
  .out_frame_last (out_frame_last)
);

[tb/sv/rcf_filter_checker.sv]
// Checker for the RGB 3x3 convolution filter: tracks the registers, predicts every pixel and compares.
module rcf_filter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [rcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_func,
  input  logic [rcf_pkg::CH_W-1:0]        in_red_in,
  input  logic [rcf_pkg::CH_W-1:0]        in_green_in,
  input  logic [rcf_pkg::CH_W-1:0]        in_blue_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [rcf_pkg::CH_W-1:0]        out_red_out,
  input  logic [rcf_pkg::CH_W-1:0]        out_green_out,
  input  logic [rcf_pkg::CH_W-1:0]        out_blue_out,
  input  logic                            out_frame_last,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [rcf_pkg::CH_W-1:0] red;
    logic [rcf_pkg::CH_W-1:0] green;
    logic [rcf_pkg::CH_W-1:0] blue;
    logic                     last;
  } filt_px_t;

  logic [rcf_pkg::SEL_W-1:0]   kernel_sel;
  logic [rcf_pkg::IMG_W_W-1:0] width_reg;
  logic [rcf_pkg::IMG_H_W-1:0] height_reg;

  rcf_pkg::pix_t line_older [rcf_pkg::MAX_WIDTH];
  rcf_pkg::pix_t line_prior [rcf_pkg::MAX_WIDTH];
  rcf_pkg::pix_t window [rcf_pkg::NUM_TAPS];
  int unsigned   in_col, in_row, out_col, out_row;
  filt_px_t      due_pixels [$];
  int            errors;

  function automatic int unsigned dim_limit(input int unsigned v, input int unsigned max_v);
    if (v < 1) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  // Weights are laid out in raster order over the window; row 0 is the row above.
  function automatic int tap_weight(input logic [rcf_pkg::SEL_W-1:0] sel, input int k);
    int r, c;
    bit is_center, is_side;
    r = k / 3;
    c = k % 3;
    is_center = (k == 4);
    is_side = (r == 1) != (c == 1);
    case (sel)
      rcf_pkg::K_BOX:     return 1;
      rcf_pkg::K_GAUSS:   return is_center ? 4 : (is_side ? 2 : 1);
      rcf_pkg::K_OUTLINE: return is_center ? 8 : -1;
      rcf_pkg::K_EMBOSS:  return is_center ? 1 : r + c - 2;
      rcf_pkg::K_SHARPEN: return is_center ? 5 : (is_side ? -1 : 0);
      default:            return 0;
    endcase
  endfunction

  function automatic logic [rcf_pkg::CH_W-1:0] convolve_channel(
      input logic [rcf_pkg::SEL_W-1:0] sel, input int lsb);
    int acc, k;
    acc = 0;
    for (k = 0; k < rcf_pkg::NUM_TAPS; k++) begin
      acc += tap_weight(sel, k) * int'(window[k][lsb +: rcf_pkg::CH_W]);
    end
    if (sel == rcf_pkg::K_BOX) begin
      acc = (acc + 4) / 9;
    end else if (sel == rcf_pkg::K_GAUSS) begin
      acc = (acc + 8) / 16;
    end
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[rcf_pkg::CH_W-1:0];
  endfunction

  // Advances the line stores and the window by one item and queues the pixel it releases.
  task automatic advance_window(input logic flush, input rcf_pkg::pix_t pix_in);
    int unsigned   w, h, c, ox, oy;
    rcf_pkg::pix_t pix, above, middle;
    logic          done, emit, interior;
    filt_px_t      px;
    w = dim_limit(32'(width_reg), rcf_pkg::MAX_WIDTH);
    h = dim_limit(32'(height_reg), rcf_pkg::MAX_HEIGHT);
    done = (in_row >= h);
    if (flush && !done) return;
    // Once the frame is in, every item drains the tail as a black pixel.
    pix = done ? '0 : pix_in;
    c = in_col;
    above = '0;
    middle = '0;
    if (c < rcf_pkg::MAX_WIDTH) begin
      above = line_older[c];
      middle = line_prior[c];
      line_older[c] = middle;
      line_prior[c] = pix;
    end
    for (int r = 0; r < 3; r++) begin
      window[r * 3] = window[r * 3 + 1];
      window[r * 3 + 1] = window[r * 3 + 2];
    end
    window[2] = above;
    window[5] = middle;
    window[8] = pix;
    emit = (in_row >= 2) || (in_row == 1 && c >= 1);
    if (c + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col = c + 1;
    end
    if (!emit) return;
    ox = out_col;
    oy = out_row;
    interior = (kernel_sel <= rcf_pkg::K_SHARPEN) && ox >= 1 && ox + 1 < w && oy >= 1 &&
               oy + 1 < h;
    px.red   = interior ? convolve_channel(kernel_sel, 16) : window[4][23:16];
    px.green = interior ? convolve_channel(kernel_sel, 8)  : window[4][15:8];
    px.blue  = interior ? convolve_channel(kernel_sel, 0)  : window[4][7:0];
    px.last  = (oy + 1 >= h) && (ox + 1 >= w);
    due_pixels.push_back(px);
    if (px.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    end else if (ox + 1 >= w) begin
      out_col = 0;
      out_row = oy + 1;
    end else begin
      out_col = ox + 1;
    end
  endtask

  task automatic compare_channel(input string what, input logic [rcf_pkg::CH_W-1:0] want,
                                 input logic [rcf_pkg::CH_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    filt_px_t want;
    if (!rst_n) begin
      kernel_sel = rcf_pkg::RST_KERNEL;
      width_reg = rcf_pkg::RST_WIDTH;
      height_reg = rcf_pkg::RST_HEIGHT;
      for (int i = 0; i < rcf_pkg::MAX_WIDTH; i++) begin
        line_older[i] = '0;
        line_prior[i] = '0;
      end
      for (int i = 0; i < rcf_pkg::NUM_TAPS; i++) window[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      due_pixels.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rcf_pkg::CFG_KERNEL: kernel_sel = cfg_wdata[rcf_pkg::SEL_W-1:0];
          rcf_pkg::CFG_WIDTH:  width_reg = cfg_wdata[rcf_pkg::IMG_W_W-1:0];
          rcf_pkg::CFG_HEIGHT: height_reg = cfg_wdata[rcf_pkg::IMG_H_W-1:0];
          default: ;
        endcase
      end
      // Results are checked before the new item is predicted; no result can be that item's own.
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual %0d %0d %0d last %0b", $time,
                   out_red_out, out_green_out, out_blue_out, out_frame_last);
          errors++;
        end else begin
          want = due_pixels.pop_front();
          compare_channel("red", want.red, out_red_out);
          compare_channel("green", want.green, out_green_out);
          compare_channel("blue", want.blue, out_blue_out);
          if (out_frame_last !== want.last) begin
            $display("%0t: frame_last mismatch, expected %0b, actual %0b", $time, want.last,
                     out_frame_last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_window(in_func, {in_red_in, in_green_in, in_blue_in});
      end
    end
    fail_count <= errors;
    pending <= due_pixels.size();
  end

endmodule

[tb/sv/tb_rgb_3x3_convolution_filter.sv]
// Testbench top for the RGB 3x3 convolution filter: clock, reset, frame stimulus and verdict.
module tb_rgb_3x3_convolution_filter;

  // No handshake for this many cycles in a row means the block has hung.
  localparam int IDLE_LIMIT = 2000;
  // Least total item count of the random frames.
  localparam int SMALL_ITEM_GOAL = 1250;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           cfg_wr_en      = 1'b0;
  logic [rcf_pkg::CFG_IDX_W-1:0]  cfg_index      = rcf_pkg::CFG_KERNEL;
  logic [rcf_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic                           in_func        = 1'b0;
  logic [rcf_pkg::CH_W-1:0]       in_red_in      = '0;
  logic [rcf_pkg::CH_W-1:0]       in_green_in    = '0;
  logic [rcf_pkg::CH_W-1:0]       in_blue_in     = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [rcf_pkg::CH_W-1:0]       out_red_out;
  logic [rcf_pkg::CH_W-1:0]       out_green_out;
  logic [rcf_pkg::CH_W-1:0]       out_blue_out;
  logic                           out_frame_last;

  int fail_count;
  int pending;

  rgb_3x3_convolution_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_frame_last (out_frame_last)
  );

  rcf_filter_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_frame_last (out_frame_last),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always #5 clk = ~clk;

  // The result side stalls in modes of its own, each held for a random span before the next is drawn:
  // no stall at all, occasional stalls, mostly stalled, and a fixed on/off rhythm.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 4);
    endcase
  end

  // The watchdog restarts on every handshake and every register write.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // The sender works in bursts; a long burst now and then gives stretches without gaps.
  int burst_left = 1;
  int small_items = 0;

  // Every task below is entered in the time step of a rising edge, so each drives with
  // nonblocking assignments that the block sees only after that edge.
  task automatic send_item(input logic f, input logic [rcf_pkg::CH_W-1:0] r,
                           input logic [rcf_pkg::CH_W-1:0] g,
                           input logic [rcf_pkg::CH_W-1:0] b);
    int gap;
    in_valid <= 1'b1;
    in_func <= f;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits until every expected pixel has come out, then lets the pipeline settle. The first row
  // of pixels and the first pixel of the next row yield nothing, so the block may still hold such
  // items after the last result.
  task automatic drain_pipeline(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty and the frame counters back at zero.
  task automatic load_setup(input logic [rcf_pkg::SEL_W-1:0] k,
                            input logic [rcf_pkg::IMG_W_W-1:0] wreg,
                            input logic [rcf_pkg::IMG_H_W-1:0] hreg);
    drain_pipeline(8);
    cfg_wr_en <= 1'b1;
    cfg_index <= rcf_pkg::CFG_KERNEL;
    cfg_wdata <= rcf_pkg::CFG_DATA_W'(k);
    @(posedge clk);
    cfg_index <= rcf_pkg::CFG_WIDTH;
    cfg_wdata <= rcf_pkg::CFG_DATA_W'(wreg);
    @(posedge clk);
    cfg_index <= rcf_pkg::CFG_HEIGHT;
    cfg_wdata <= hreg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int dim_of(input int v, input int max_v);
    return (v < 1) ? 1 : ((v > max_v) ? max_v : v);
  endfunction

  function automatic logic [rcf_pkg::CH_W-1:0] pick_level(input bit extremes);
    if (extremes) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return rcf_pkg::CH_W'($urandom_range(0, 255));
  endfunction

  // One whole frame: its pixels in raster order, with a stray flush now and then that the
  // block must ignore, then one row plus one item of tail. Tail items are a random mix of
  // flushes and pixels, since a pixel after the frame is in counts as a flush.
  task automatic run_frame(input logic [rcf_pkg::SEL_W-1:0] k,
                           input logic [rcf_pkg::IMG_W_W-1:0] wreg,
                           input logic [rcf_pkg::IMG_H_W-1:0] hreg, input bit reload,
                           input bit counted);
    int w, h, n;
    bit extremes;
    w = dim_of(int'(wreg), rcf_pkg::MAX_WIDTH);
    h = dim_of(int'(hreg), rcf_pkg::MAX_HEIGHT);
    extremes = ($urandom_range(0, 3) == 0);
    if (reload) load_setup(k, wreg, hreg);
    for (n = 0; n < w * h; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(1'b1, pick_level(1'b0), pick_level(1'b0), pick_level(1'b0));
      end
      send_item(1'b0, pick_level(extremes), pick_level(extremes), pick_level(extremes));
    end
    for (n = 0; n <= w; n++) begin
      send_item(1'($urandom_range(0, 1)), pick_level(1'b0), pick_level(1'b0),
                pick_level(1'b0));
    end
    if (counted) small_items += w * h + w + 1;
  endtask

  initial begin
    logic [rcf_pkg::SEL_W-1:0]   k;
    logic [rcf_pkg::IMG_W_W-1:0] wreg;
    logic [rcf_pkg::IMG_H_W-1:0] hreg;
    bit                          reload, prev_big;
    int                          frame;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Outline on a 3x3 frame: the one interior pixel drives red far above 255 and green far
    // below 0, so both ends of the clamp are hit. A flush ahead of the frame is ignored, and
    // a pixel inside the tail acts as a flush.
    load_setup(rcf_pkg::K_OUTLINE, 12'd3, 13'd3);
    send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
    for (int n = 0; n < 9; n++) begin
      send_item(1'b0, (n == 4) ? 8'hFF : 8'h00, (n == 4) ? 8'h00 : 8'hFF,
                (n == 4) ? 8'hC8 : 8'h0A);
    end
    send_item(1'b0, 8'hAB, 8'hCD, 8'hEF);
    repeat (3) send_item(1'b1, 8'h00, 8'h00, 8'h00);

    // An undefined kernel code on a single-pixel frame: the pixel passes through as is.
    load_setup(3'd7, 12'd1, 13'd1);
    send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_item(1'b1, 8'h00, 8'h00, 8'h00);
    send_item(1'b0, 8'h55, 8'hAA, 8'h55);

    // Random frames. The first eight walk through every kernel code; two fixed slots carry
    // a zero width and a zero height, which both count as one. Some frames reuse the
    // previous setup and follow it back to back.
    k = rcf_pkg::K_BOX;
    wreg = 12'd1;
    hreg = 13'd1;
    prev_big = 1'b0;
    for (frame = 0; small_items < SMALL_ITEM_GOAL || frame < 24; frame++) begin
      case (frame)
        4: begin
          run_frame(rcf_pkg::K_SHARPEN, 12'd0, 13'd3, 1'b1, 1'b1);
          prev_big = 1'b1;
        end
        8: begin
          run_frame(rcf_pkg::K_GAUSS, 12'd6, 13'd0, 1'b1, 1'b1);
          prev_big = 1'b1;
        end
        default: begin
          reload = (frame < 8) || prev_big || ($urandom_range(0, 2) != 0);
          if (reload) begin
            if (frame < 8) begin
              k = rcf_pkg::SEL_W'(frame);
            end else begin
              k = rcf_pkg::SEL_W'($urandom_range(0, 11));
              k = (k >= 3'd5) ? rcf_pkg::SEL_W'(k % 5) : k;
              if ($urandom_range(0, 9) == 0) k = rcf_pkg::SEL_W'($urandom_range(5, 7));
            end
            if ($urandom_range(0, 4) == 0) begin
              wreg = rcf_pkg::IMG_W_W'($urandom_range(13, 48));
              hreg = rcf_pkg::IMG_H_W'($urandom_range(3, 4));
            end else begin
              wreg = rcf_pkg::IMG_W_W'($urandom_range(1, 12));
              hreg = rcf_pkg::IMG_H_W'($urandom_range(1, 8));
            end
          end
          run_frame(k, wreg, hreg, reload, 1'b1);
          prev_big = 1'b0;
        end
      endcase
    end

    drain_pipeline(20);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
